### design/assert_macros.svh
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/wrs_pkg.sv
// Types, constants and saturation helpers for the winding row sweep.
`timescale 1ns / 1ps

package wrs_pkg;

	localparam int ROW_W    = 17;
	localparam int ID_W     = 16;
	localparam int COV_W    = 19;
	localparam int DELTA_W  = 7;
	localparam int WIND_W   = 8;
	localparam int WEIGHT_W = 17;
	localparam int TOL_W    = 8;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	// two completed cells per beat, each a gap run and a cell result
	localparam int SLOTS      = 4;
	localparam int SLOT_IDX_W = 2;

	localparam logic KIND_RUN  = 1'b0;
	localparam logic KIND_EDGE = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_APPROX = 1'b0;
	localparam logic REG_TOL    = 1'b1;

	typedef logic [ROW_W-1:0]           row_t;
	typedef logic [ID_W-1:0]            id_t;
	typedef logic signed [COV_W-1:0]    cov_t;
	typedef logic signed [DELTA_W-1:0]  delta_t;
	typedef logic signed [WIND_W-1:0]   wind_t;
	typedef logic [WEIGHT_W-1:0]        weight_t;
	typedef logic [TOL_W-1:0]           tol_t;

	localparam wind_t WIND_MAX = {1'b0, {(WIND_W-1){1'b1}}};
	localparam wind_t WIND_MIN = {1'b1, {(WIND_W-1){1'b0}}};
	localparam cov_t  COV_MAX  = {1'b0, {(COV_W-1){1'b1}}};
	localparam cov_t  COV_MIN  = {1'b1, {(COV_W-1){1'b0}}};

	function automatic wind_t sat_wind(input logic signed [WIND_W:0] v);
		wind_t r;
		if (v[WIND_W] == v[WIND_W-1]) begin
			r = v[WIND_W-1:0];
		end else begin
			r = v[WIND_W] ? WIND_MIN : WIND_MAX;
		end
		return r;
	endfunction

	function automatic cov_t sat_cov(input logic signed [COV_W:0] v);
		cov_t r;
		if (v[COV_W] == v[COV_W-1]) begin
			r = v[COV_W-1:0];
		end else begin
			r = v[COV_W] ? COV_MIN : COV_MAX;
		end
		return r;
	endfunction

endpackage

### design/wrs_chan_if.sv
// Record and result channel interfaces of the winding row sweep.
`timescale 1ns / 1ps

interface wrs_rec_if #(parameter int COLUMN_BITS = 16);
	import wrs_pkg::*;

	logic                     valid;
	logic                     ready;
	row_t                     row_index;
	logic signed [COLUMN_BITS:0] column;
	cov_t                     coverage;
	delta_t                   wind_delta;
	delta_t                   winding_left_delta;
	id_t                      shape_id;
	logic                     row_end;

	modport source (output valid, row_index, column, coverage, wind_delta,
		winding_left_delta, shape_id, row_end, input ready);
	modport sink (input valid, row_index, column, coverage, wind_delta,
		winding_left_delta, shape_id, row_end, output ready);
endinterface

interface wrs_res_if #(parameter int COLUMN_BITS = 16);
	import wrs_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	row_t               out_row;
	logic [COLUMN_BITS:0] first_column;
	logic [COLUMN_BITS:0] last_column;
	weight_t            weight;
	id_t                out_id;
	logic               last_of_item;

	modport source (output valid, kind, out_row, first_column, last_column, weight,
		out_id, last_of_item, input ready);
	modport sink (input valid, kind, out_row, first_column, last_column, weight,
		out_id, last_of_item, output ready);
endinterface

### design/wrs_cell_eval.sv
// Completion of one merged cell: gap run, cell classification, winding advance.
`timescale 1ns / 1ps

module wrs_cell_eval #(
	parameter int COLUMN_BITS   = 16,
	parameter int FRACTION_BITS = 16,
	parameter type res_t        = logic
) (
	input  logic                        approx,
	input  wrs_pkg::tol_t               tol,
	input  wrs_pkg::wind_t              wind,
	input  logic signed [COLUMN_BITS+1:0] prior_col,
	input  wrs_pkg::row_t               row,
	input  wrs_pkg::id_t                id,
	input  logic signed [COLUMN_BITS:0] col,
	input  wrs_pkg::cov_t               cov,
	input  wrs_pkg::wind_t              wd,
	input  wrs_pkg::wind_t              wl,
	output logic                        gap_valid,
	output res_t                        gap_res,
	output logic                        cell_valid,
	output res_t                        cell_res,
	output wrs_pkg::wind_t              wind_next,
	output logic signed [COLUMN_BITS+1:0] prev_next
);
	import wrs_pkg::*;

	localparam int COL_W = COLUMN_BITS + 1;
	localparam int CMP_W = (FRACTION_BITS + 2 > COV_W + 1) ? FRACTION_BITS + 2 : COV_W + 1;

	localparam logic signed [COL_W+1:0] ONE_X     = (COL_W+2)'(1);
	localparam logic signed [COL_W+1:0] TWO_X     = (COL_W+2)'(2);
	localparam logic signed [COL_W+1:0] NEG_TWO_X = -(COL_W+2)'(2);
	localparam logic signed [CMP_W-1:0] FULL_X    = CMP_W'(1 << FRACTION_BITS);

	logic signed [COL_W+1:0]  col_x;
	logic signed [COL_W+1:0]  prev_x;
	logic signed [CMP_W-1:0]  cov_x;
	logic signed [CMP_W-1:0]  tol_x;
	logic signed [CMP_W-1:0]  hi_x;
	logic signed [WIND_W:0]   centre_w;
	logic [COL_W-1:0]         cell_col;
	logic                     edge_hit;
	logic                     full_hit;

	assign col_x  = (COL_W+2)'(col);
	assign prev_x = (COL_W+2)'(prior_col);

	// run across the skipped columns, one-based prev+2 .. col
	assign gap_valid = (wind != '0) && (prev_x > NEG_TWO_X) && (col_x > prev_x + ONE_X);

	always_comb begin
		gap_res              = '0;
		gap_res.kind         = KIND_RUN;
		gap_res.out_row      = row;
		gap_res.first_column = COL_W'(prev_x + TWO_X);
		gap_res.last_column  = col;
		gap_res.weight       = '0;
		gap_res.out_id       = id;
	end

	assign cov_x = CMP_W'(cov);
	assign tol_x = CMP_W'(tol);
	assign hi_x  = FULL_X - tol_x;

	assign edge_hit = (cov_x > tol_x) && (cov_x < hi_x);
	assign full_hit = (cov_x >= hi_x);

	// winding at the cell centre
	assign centre_w = (WIND_W+1)'(wind) + (WIND_W+1)'(wl);

	assign cell_valid = approx ? (centre_w != '0) : (edge_hit || full_hit);
	assign cell_col   = COL_W'(col_x + ONE_X);

	always_comb begin
		cell_res              = '0;
		cell_res.kind         = (!approx && edge_hit) ? KIND_EDGE : KIND_RUN;
		cell_res.out_row      = row;
		cell_res.first_column = cell_col;
		cell_res.last_column  = cell_col;
		cell_res.weight       = (!approx && edge_hit) ? cov[WEIGHT_W-1:0] : '0;
		cell_res.out_id       = id;
	end

	assign wind_next = sat_wind((WIND_W+1)'(wind) + (WIND_W+1)'(wd));
	assign prev_next = (COL_W+1)'(col);

endmodule

### design/wrs_result_buf.sv
// Result register: holds the results of one beat and drains them in order.
`timescale 1ns / 1ps

module wrs_result_buf #(
	parameter type res_t = logic
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [wrs_pkg::SLOTS-1:0]  load_valid,
	input  res_t                       load_data [wrs_pkg::SLOTS],
	output logic                       can_load,
	output logic                       out_valid,
	input  logic                       out_ready,
	output res_t                       out_data,
	output logic                       out_last
);
	import wrs_pkg::*;

	logic [SLOTS-1:0]      mask_q;
	res_t                  data_q [SLOTS];
	logic [SLOTS-1:0]      sel;
	logic [SLOTS-1:0]      rest;
	logic [SLOT_IDX_W-1:0] idx;
	logic                  found;
	logic                  fire;

	// lowest occupied slot goes out first
	always_comb begin
		sel   = '0;
		idx   = '0;
		found = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (mask_q[i] && !found) begin
				sel[i] = 1'b1;
				idx    = SLOT_IDX_W'(i);
				found  = 1'b1;
			end
		end
	end

	assign rest      = mask_q & ~sel;
	assign out_valid = |mask_q;
	assign out_data  = data_q[idx];
	assign out_last  = (rest == '0);
	assign fire      = out_valid && out_ready;
	assign can_load  = (mask_q == '0) || (fire && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= load_valid;
		end else if (fire) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

### design/winding_row_sweep.sv
// Nonzero-winding span fill over one row of sorted boundary-cell records.
// Usage:
//   records: one boundary-cell record per beat, sorted by column within a row;
//     row_end marks the last record of a row. Records of the same column, row
//     and shape merge into one pending cell.
//   results: runs and edge cells, one per beat; last_of_item flags the final
//     result caused by a record. A record causes zero to four results.
//   APB port: register 0 (approx_mode) at 0x0, register 1 (tolerance) at 0x4;
//     write only while the block is idle. pready is always high.
// A record's first result reaches results through the input register and then
//   the result register; a full result register holds the record back.
// The result register drains one result per cycle while results.ready is high;
//   a record with several results holds it until its last one is taken, so
//   records flow at one per cycle when results are sparse.
// Reset clears the winding count, the previous column, the pending cell and
//   both registers. A stalled result side keeps the result register full; one
//   more record waits in the input register, then records.ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module winding_row_sweep #(
	parameter int COLUMN_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	wrs_rec_if.sink                       records,
	wrs_res_if.source                     results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wrs_pkg::ADDR_W-1:0]    paddr,
	input  logic [wrs_pkg::DATA_W-1:0]    pwdata,
	output logic [wrs_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import wrs_pkg::*;

	localparam int COL_W = COLUMN_BITS + 1;
	localparam logic signed [COL_W:0] PREV_RESET = -(COL_W+1)'(2);

	typedef struct packed {
		logic             kind;
		row_t             out_row;
		logic [COL_W-1:0] first_column;
		logic [COL_W-1:0] last_column;
		weight_t          weight;
		id_t              out_id;
	} res_t;

	// configuration
	logic approx_q;
	tol_t tol_q;
	logic cfg_wr;

	// input register
	logic                     valid_s1;
	row_t                     row_s1;
	logic signed [COL_W-1:0]  col_s1;
	cov_t                     cov_s1;
	delta_t                   wd_s1;
	delta_t                   wl_s1;
	id_t                      id_s1;
	logic                     row_end_s1;

	// sweep state
	wind_t                    wind_q;
	logic signed [COL_W:0]    prev_q;
	logic                     pv_q;
	logic signed [COL_W-1:0]  pcol_q;
	cov_t                     pcov_q;
	wind_t                    pwd_q;
	wind_t                    pwl_q;
	row_t                     prow_q;
	id_t                      pid_q;

	logic                     in_fire;
	logic                     take;
	logic                     can_load;
	logic                     match;
	logic                     a_on;

	cov_t                     np_cov;
	wind_t                    np_wd;
	wind_t                    np_wl;

	logic                     a_gap_v, a_cell_v, b_gap_v, b_cell_v;
	res_t                     a_gap, a_cell, b_gap, b_cell;
	wind_t                    a_wind, b_wind, wind_a;
	logic signed [COL_W:0]    a_prev, b_prev, prev_a;

	logic [SLOTS-1:0]         slot_valid;
	res_t                     slot_data [SLOTS];
	res_t                     out_res;
	logic                     out_last;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			approx_q <= 1'b0;
			tol_q    <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_APPROX: approx_q <= pwdata[0];
				REG_TOL:    tol_q    <= pwdata[TOL_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_APPROX: prdata = DATA_W'(approx_q);
			REG_TOL:    prdata = DATA_W'(tol_q);
			default:    prdata = '0;
		endcase
	end

	// input register
	assign take          = valid_s1 && can_load;
	assign records.ready = !valid_s1 || take;
	assign in_fire       = records.valid && records.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_s1     <= records.row_index;
			col_s1     <= records.column;
			cov_s1     <= records.coverage;
			wd_s1      <= records.wind_delta;
			wl_s1      <= records.winding_left_delta;
			id_s1      <= records.shape_id;
			row_end_s1 <= records.row_end;
		end
	end

	// merge into the pending cell or close it
	assign match = pv_q && (pcol_q == col_s1) && (prow_q == row_s1) && (pid_q == id_s1);
	assign a_on  = pv_q && !match;

	always_comb begin
		if (match) begin
			np_cov = sat_cov((COV_W+1)'(pcov_q) + (COV_W+1)'(cov_s1));
			np_wd  = sat_wind((WIND_W+1)'(pwd_q) + (WIND_W+1)'(wd_s1));
			np_wl  = sat_wind((WIND_W+1)'(pwl_q) + (WIND_W+1)'(wl_s1));
		end else begin
			np_cov = cov_s1;
			np_wd  = WIND_W'(wd_s1);
			np_wl  = WIND_W'(wl_s1);
		end
	end

	// previously pending cell, closed by a new column, row or shape
	wrs_cell_eval #(
		.COLUMN_BITS   (COLUMN_BITS),
		.FRACTION_BITS (FRACTION_BITS),
		.res_t         (res_t)
	) u_cell_a (
		.approx     (approx_q),
		.tol        (tol_q),
		.wind       (wind_q),
		.prior_col  (prev_q),
		.row        (prow_q),
		.id         (pid_q),
		.col        (pcol_q),
		.cov        (pcov_q),
		.wd         (pwd_q),
		.wl         (pwl_q),
		.gap_valid  (a_gap_v),
		.gap_res    (a_gap),
		.cell_valid (a_cell_v),
		.cell_res   (a_cell),
		.wind_next  (a_wind),
		.prev_next  (a_prev)
	);

	assign wind_a = a_on ? a_wind : wind_q;
	assign prev_a = a_on ? a_prev : prev_q;

	// cell holding this record, closed at row end
	wrs_cell_eval #(
		.COLUMN_BITS   (COLUMN_BITS),
		.FRACTION_BITS (FRACTION_BITS),
		.res_t         (res_t)
	) u_cell_b (
		.approx     (approx_q),
		.tol        (tol_q),
		.wind       (wind_a),
		.prior_col  (prev_a),
		.row        (row_s1),
		.id         (id_s1),
		.col        (col_s1),
		.cov        (np_cov),
		.wd         (np_wd),
		.wl         (np_wl),
		.gap_valid  (b_gap_v),
		.gap_res    (b_gap),
		.cell_valid (b_cell_v),
		.cell_res   (b_cell),
		.wind_next  (b_wind),
		.prev_next  (b_prev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= 1'b0;
			wind_q <= '0;
			prev_q <= PREV_RESET;
		end else if (take) begin
			if (row_end_s1) begin
				pv_q   <= 1'b0;
				wind_q <= '0;
				prev_q <= PREV_RESET;
			end else begin
				pv_q   <= 1'b1;
				wind_q <= wind_a;
				prev_q <= prev_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pcol_q <= col_s1;
			pcov_q <= np_cov;
			pwd_q  <= np_wd;
			pwl_q  <= np_wl;
			prow_q <= row_s1;
			pid_q  <= id_s1;
		end
	end

	// slot order: closed cell gap, closed cell, row-end gap, row-end cell
	assign slot_valid = {row_end_s1 && b_cell_v, row_end_s1 && b_gap_v,
		a_on && a_cell_v, a_on && a_gap_v};

	always_comb begin
		slot_data[0] = a_gap;
		slot_data[1] = a_cell;
		slot_data[2] = b_gap;
		slot_data[3] = b_cell;
	end

	wrs_result_buf #(
		.res_t (res_t)
	) u_result_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take),
		.load_valid (slot_valid),
		.load_data  (slot_data),
		.can_load   (can_load),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.out_data   (out_res),
		.out_last   (out_last)
	);

	assign results.kind         = out_res.kind;
	assign results.out_row      = out_res.out_row;
	assign results.first_column = out_res.first_column;
	assign results.last_column  = out_res.last_column;
	assign results.weight       = out_res.weight;
	assign results.out_id       = out_res.out_id;
	assign results.last_of_item = out_last;

	`ASSERT_NEXT(a_row_end_clears, clk, arst_n, take && row_end_s1, !pv_q && wind_q == '0 && prev_q == PREV_RESET)
	`ASSERT_NEXT(a_pending_set, clk, arst_n, take && !row_end_s1, pv_q && pcol_q == $past(col_s1))
	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !take, valid_s1 && $stable(col_s1) && $stable(row_s1))
	`ASSERT_IMPLY(a_edge_one_cell, clk, arst_n, results.valid && results.kind == KIND_EDGE, results.first_column == results.last_column)

endmodule

### test/testbench.sv
// Self-checking testbench for the winding row sweep: records in, runs and edge cells out.
`timescale 1ns / 1ps

module testbench;
	import wrs_pkg::*;

	localparam int FULL_Q16 = 1 << 16;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		row_t row;
		logic signed [16:0] col;
		cov_t cov;
		delta_t wd;
		delta_t wl;
		id_t id;
		logic row_end;
	} rec_t;

	typedef struct {
		logic kind;
		row_t row;
		logic [16:0] first;
		logic [16:0] last;
		weight_t weight;
		id_t id;
		logic last_flag;
	} span_t;

	// Tracks winding state per row and the spans each record must produce.
	class span_scoreboard;
		localparam int FULL_Q = 1 << 16;

		bit cfg_approx;
		int cfg_tol;
		int winding;
		int prior_col;
		bit pend_valid;
		int pend_col;
		int pend_cov;
		int pend_wd;
		int pend_wl;
		row_t pend_row;
		id_t pend_id;
		span_t fresh[$];
		span_t spans_due[$];
		int errors;

		function new();
			cfg_approx = 0;
			cfg_tol = 0;
			winding = 0;
			prior_col = -2;
			pend_valid = 0;
			errors = 0;
		endfunction

		function void set_reg(logic idx, int unsigned value);
			if (idx == REG_APPROX) begin
				cfg_approx = value[0];
			end else begin
				cfg_tol = value & 8'hFF;
			end
		endfunction

		function int clip(int v, int w);
			int hi;
			hi = (1 << (w - 1)) - 1;
			return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
		endfunction

		function void emit(logic kind, int first, int last, int weight);
			span_t s;
			s.kind = kind;
			s.row = pend_row;
			s.first = 17'(first);
			s.last = 17'(last);
			s.weight = 17'(weight);
			s.id = pend_id;
			s.last_flag = 1'b0;
			fresh = {fresh, s};
		endfunction

		function void close_cell();
			if (winding != 0 && prior_col > -2 && pend_col > prior_col + 1) begin
				emit(KIND_RUN, prior_col + 2, pend_col, 0);
			end
			if (cfg_approx) begin
				if (winding + pend_wl != 0) begin
					emit(KIND_RUN, pend_col + 1, pend_col + 1, 0);
				end
			end else if (pend_cov > cfg_tol && pend_cov < FULL_Q - cfg_tol) begin
				emit(KIND_EDGE, pend_col + 1, pend_col + 1, pend_cov);
			end else if (pend_cov >= FULL_Q - cfg_tol) begin
				emit(KIND_RUN, pend_col + 1, pend_col + 1, 0);
			end
			winding = clip(winding + pend_wd, 8);
			prior_col = pend_col;
		endfunction

		function void note_record(rec_t r);
			int c;
			c = r.col;
			fresh.delete();
			if (pend_valid && pend_col == c && pend_row == r.row && pend_id == r.id) begin
				pend_cov = clip(pend_cov + int'(r.cov), 19);
				pend_wd = clip(pend_wd + int'(r.wd), 8);
				pend_wl = clip(pend_wl + int'(r.wl), 8);
			end else begin
				if (pend_valid) begin
					close_cell();
				end
				pend_valid = 1;
				pend_col = c;
				pend_cov = r.cov;
				pend_wd = r.wd;
				pend_wl = r.wl;
				pend_row = r.row;
				pend_id = r.id;
			end
			if (r.row_end) begin
				close_cell();
				pend_valid = 0;
				winding = 0;
				prior_col = -2;
			end
			if (fresh.size() > 0) begin
				fresh[fresh.size() - 1].last_flag = 1'b1;
			end
			foreach (fresh[i]) begin
				spans_due = {spans_due, fresh[i]};
			end
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_span(span_t got);
			span_t want;
			if (spans_due.size() == 0) begin
				report_mismatch($sformatf("span with none due, row %0d col %0d..%0d",
					got.row, got.first, got.last));
				return;
			end
			want = spans_due.pop_front();
			if (got.kind !== want.kind)
				report_mismatch($sformatf("kind %b, want %b", got.kind, want.kind));
			if (got.row !== want.row)
				report_mismatch($sformatf("out_row %0d, want %0d", got.row, want.row));
			if (got.first !== want.first)
				report_mismatch($sformatf("first_column %0d, want %0d", got.first, want.first));
			if (got.last !== want.last)
				report_mismatch($sformatf("last_column %0d, want %0d", got.last, want.last));
			if (got.weight !== want.weight)
				report_mismatch($sformatf("weight %0d, want %0d", got.weight, want.weight));
			if (got.id !== want.id)
				report_mismatch($sformatf("out_id %0d, want %0d", got.id, want.id));
			if (got.last_flag !== want.last_flag)
				report_mismatch($sformatf("last_of_item %b, want %b", got.last_flag,
					want.last_flag));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	wrs_rec_if #(.COLUMN_BITS(16)) rec_ch();
	wrs_res_if #(.COLUMN_BITS(16)) res_ch();

	winding_row_sweep #(.COLUMN_BITS(16), .FRACTION_BITS(16)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.records(rec_ch),
		.results(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	span_scoreboard sb;
	bit quiet;
	int records_sent;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rec_t mk(int row, int col, int cov, int wd, int wl, int id,
		bit row_end);
		rec_t r;
		r.row = 17'(row);
		r.col = 17'(col);
		r.cov = 19'(cov);
		r.wd = 7'(wd);
		r.wl = 7'(wl);
		r.id = 16'(id);
		r.row_end = row_end;
		return r;
	endfunction

	task automatic send_rec(rec_t r);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			rec_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rec_ch.valid <= 1'b1;
		rec_ch.row_index <= r.row;
		rec_ch.column <= r.col;
		rec_ch.coverage <= r.cov;
		rec_ch.wind_delta <= r.wd;
		rec_ch.winding_left_delta <= r.wl;
		rec_ch.shape_id <= r.id;
		rec_ch.row_end <= r.row_end;
		do @(posedge clk); while (!rec_ch.ready);
		sb.note_record(r);
		records_sent++;
	endtask

	// Drain every due span, then give the pipeline time to empty.
	task automatic wait_quiet();
		rec_ch.valid <= 1'b0;
		while (sb.spans_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	function automatic int pick_cov();
		int t;
		t = sb.cfg_tol;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return t;
			2: return t + 1;
			3: return FULL_Q16 - t - 1;
			4: return FULL_Q16 - t;
			5: return FULL_Q16;
			6: return -int'($urandom_range(1, FULL_Q16));
			7: return int'($urandom_range(0, 19'h7FFFF)) - (1 << 18);
			default: return $urandom_range(1, FULL_Q16 - 1);
		endcase
	endfunction

	function automatic int pick_delta(bit heavy);
		if (heavy || $urandom_range(0, 15) == 0) begin
			return int'($urandom_range(0, 127)) - 64;
		end
		return int'($urandom_range(0, 4)) - 2;
	endfunction

	// One well-formed row: sorted columns, some repeats to merge, row_end at the close.
	task automatic send_row();
		int row;
		int id;
		int col;
		int n;
		bit heavy;
		row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17'h1FFFF) : $urandom_range(1, 9);
		id = $urandom_range(0, 16'hFFFF);
		n = $urandom_range(1, 7);
		heavy = ($urandom_range(0, 5) == 0);
		case ($urandom_range(0, 3))
			0: col = -1;
			1: col = 65535 - 3 * n;
			default: col = $urandom_range(0, 12);
		endcase
		for (int i = 0; i < n; i++) begin
			send_rec(mk(row, col, pick_cov(), pick_delta(heavy), pick_delta(heavy), id,
				i == n - 1));
			case ($urandom_range(0, 3))
				0: col = col;
				1: col = col + 1;
				default: col = col + $urandom_range(2, 5);
			endcase
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 3)) begin
			send_rec(mk($urandom_range(0, 17'h1FFFF), $urandom_range(0, 17'h1FFFF),
				$urandom_range(0, 19'h7FFFF), $urandom_range(0, 127),
				$urandom_range(0, 127), $urandom_range(0, 16'hFFFF),
				$urandom_range(0, 3) == 0));
		end
	endtask

	task automatic random_rows(int target);
		while (records_sent < target) begin
			if ($urandom_range(0, 9) < 8) begin
				send_row();
			end else begin
				send_noise();
			end
			if ($urandom_range(0, 19) == 0) begin
				wait_quiet();
			end
		end
	endtask

	// Result side: check each beat, stall in short random bursts.
	initial begin
		int stall;
		span_t got;
		stall = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.kind = res_ch.kind;
				got.row = res_ch.out_row;
				got.first = res_ch.first_column;
				got.last = res_ch.last_column;
				got.weight = res_ch.weight;
				got.id = res_ch.out_id;
				got.last_flag = res_ch.last_of_item;
				sb.check_span(got);
			end
			if (stall > 0) begin
				stall--;
				res_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 4) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		sb = new();
		quiet = 0;
		records_sent = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rec_ch.valid = 1'b0;
		rec_ch.row_index = '0;
		rec_ch.column = '0;
		rec_ch.coverage = '0;
		rec_ch.wind_delta = '0;
		rec_ch.winding_left_delta = '0;
		rec_ch.shape_id = '0;
		rec_ch.row_end = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_APPROX, 0);
		write_reg(REG_TOL, 0);

		// padding column on entry, merged half cells, gap run, edge at row end
		send_rec(mk(1, -1, 0, 1, 0, 1, 0));
		send_rec(mk(1, 2, 32768, 0, 0, 1, 0));
		send_rec(mk(1, 2, 32768, -1, 0, 1, 0));
		send_rec(mk(1, 5, 100, 0, 0, 1, 1));
		// four spans from one beat: two gaps and two cells
		send_rec(mk(2, 0, FULL_Q16, 1, 0, 2, 0));
		send_rec(mk(2, 3, FULL_Q16, 0, 0, 2, 0));
		send_rec(mk(2, 6, 30000, 0, 0, 2, 1));
		// field extremes, column below the padding column
		send_rec(mk(65536, 65535, 262143, 63, -64, 65535, 1));
		send_rec(mk(3, -65536, -262144, -64, 63, 3, 1));
		// saturating merges, then a shape change without row end and unsorted columns
		send_rec(mk(4, 0, 262143, 63, 63, 4, 0));
		send_rec(mk(4, 0, 262143, 63, 63, 4, 0));
		send_rec(mk(4, 0, 262143, 63, 63, 4, 0));
		send_rec(mk(4, 10, -5, 63, -64, 4, 0));
		send_rec(mk(4, 20, FULL_Q16 - 1, 0, 0, 4, 0));
		send_rec(mk(4, 25, 1, 0, 0, 5, 0));
		send_rec(mk(4, 3, 0, -64, 0, 5, 0));
		send_rec(mk(4, 1, FULL_Q16, 0, 0, 5, 1));
		wait_quiet();

		write_reg(REG_TOL, 255);
		send_rec(mk(5, 0, 255, 0, 0, 6, 0));
		send_rec(mk(5, 1, 256, 0, 0, 6, 0));
		send_rec(mk(5, 2, FULL_Q16 - 255, 0, 0, 6, 0));
		send_rec(mk(5, 3, FULL_Q16 - 256, 0, 0, 6, 1));
		wait_quiet();

		write_reg(REG_APPROX, 1);
		send_rec(mk(6, 0, 0, 1, 1, 7, 0));
		send_rec(mk(6, 2, 0, -1, 0, 7, 0));
		send_rec(mk(6, 4, 0, 0, 0, 7, 1));
		wait_quiet();

		write_reg(REG_APPROX, 0);
		write_reg(REG_TOL, $urandom_range(0, 255));
		random_rows(90);
		wait_quiet();
		write_reg(REG_APPROX, 1);
		random_rows(150);
		wait_quiet();
		write_reg(REG_APPROX, 0);
		write_reg(REG_TOL, 0);
		random_rows(210);
		wait_quiet();
		write_reg(REG_APPROX, $urandom_range(0, 1));
		write_reg(REG_TOL, 255);
		quiet = 1;
		random_rows(250);

		rec_ch.valid <= 1'b0;
		while (sb.spans_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.spans_due.size() != 0) begin
			sb.report_mismatch($sformatf("%0d spans never arrived", sb.spans_due.size()));
		end
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
